[sv/pbwt_pkg.sv]
// ----------------------------------------------------------------------------
// pbwt_pkg
// Shared constants and types for the plethysmograph beat and window tracker.
// ----------------------------------------------------------------------------
package pbwt_pkg;

    localparam int PLOT_SLOTS_DEF = 120;
    localparam int WINDOW_LEN_DEF = 76;

    localparam int SAMPLE_W = 16;
    localparam int MODE_W   = 2;
    localparam int SCALE_W  = 4;
    localparam int RUN_W    = 3;
    localparam int CFG_IX_W = 2;
    localparam int SLOT_W   = 7;
    localparam int CURSOR_W = 10;
    localparam int RATE_W   = 16;

    localparam logic [MODE_W-1:0] MODE_SAMPLE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REQUEST = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd2;

    localparam logic [CFG_IX_W-1:0] REG_FLOOR = 2'd0;
    localparam logic [CFG_IX_W-1:0] REG_SCALE = 2'd1;
    localparam logic [CFG_IX_W-1:0] REG_RUN   = 2'd2;

    localparam logic [SAMPLE_W-1:0] FLOOR_RESET = 16'd100;
    localparam logic [SCALE_W-1:0]  SCALE_RESET = 4'd4;
    localparam logic [RUN_W-1:0]    RUN_RESET   = 3'd3;

    localparam int CURSOR_KNEE    = 500;
    localparam int CURSOR_OFS_HI  = 25;
    localparam int CURSOR_OFS_LO  = 28;
    localparam int CURSOR_MAX     = 1023;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'hFFFF;
    localparam logic [RATE_W-1:0]   RATE_MAX   = 16'hFFFF;

    typedef struct packed {
        logic write;
        logic start;
    } ring_ctl_t;

    typedef struct packed {
        logic done;
        logic [SAMPLE_W-1:0] lo;
        logic [SAMPLE_W-1:0] hi;
    } ring_stat_t;

    typedef struct packed {
        logic take;
        logic request;
        logic clear;
    } beat_ctl_t;

endpackage

[sv/pleth_beat_and_window_tracker_unit.sv]
// ----------------------------------------------------------------------------
// pleth_beat_and_window_tracker_unit
// Plethysmograph tracker: display slot and cursor, window min/max, beat rate.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid/item_ready): mode and sample. A sample at or
//   above the floor gives one result word; a clear gives one result word with
//   cleared set; a report request, a sample below the floor and an unused
//   mode give none and do not hold the unit.
//   result channel (result_valid/result_ready): one registered output word.
//   A sample holds the unit while the min/max sweep reads the filled ring
//   entries one entry per cycle through one compare unit; its word then
//   waits in S_LOAD until the output register is free. A clear goes to
//   S_LOAD directly and holds the unit until its word is loaded into the
//   output register.
//   item_ready is low while a word is being worked on and while a finished
//   word waits for a full output register; a stalled receiver holds the
//   output word and, after that, blocks the next result-giving word.
//   cfg_write/cfg_index/cfg_data write sample_floor, report_scale and
//   run_length; write only while the unit is idle.
//   Reset clears all counters, the window fill and the output valid flag; the
//   ring contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module pleth_beat_and_window_tracker_unit #(
    parameter int PLOT_SLOTS = pbwt_pkg::PLOT_SLOTS_DEF,
    parameter int WINDOW_LEN = pbwt_pkg::WINDOW_LEN_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [pbwt_pkg::CFG_IX_W-1:0] cfg_index,
    input  logic [pbwt_pkg::SAMPLE_W-1:0] cfg_data,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic [pbwt_pkg::MODE_W-1:0]   mode,
    input  logic [pbwt_pkg::SAMPLE_W-1:0] sample,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic                          cleared,
    output logic [pbwt_pkg::SAMPLE_W-1:0] window_min,
    output logic [pbwt_pkg::SAMPLE_W-1:0] window_max,
    output logic [pbwt_pkg::SLOT_W-1:0]   slot,
    output logic                          wrap_strobe,
    output logic                          cursor_valid,
    output logic [pbwt_pkg::CURSOR_W-1:0] cursor,
    output logic                          rate_valid,
    output logic [pbwt_pkg::RATE_W-1:0]   beat_rate
);
    import pbwt_pkg::*;

    localparam int SCW = $clog2(PLOT_SLOTS + 1);
    localparam int AW  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int RCW = $clog2(WINDOW_LEN + 1);
    localparam int CUR_W = (SCW + 4 > 11) ? SCW + 4 : 11;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SWEEP = 2'd1;
    localparam logic [1:0] S_LOAD  = 2'd2;

    logic [1:0] state_reg, state_next;

    logic [SAMPLE_W-1:0] floor_reg;
    logic [SCALE_W-1:0]  scale_reg;
    logic [RUN_W-1:0]    run_len_reg;

    logic [SCW-1:0] filled_reg, filled_next;
    logic [SCW-1:0] sidx_reg, sidx_next;
    logic [RCW-1:0] rfill_reg, rfill_next;
    logic [AW-1:0]  ridx_reg, ridx_next;

    logic                res_cleared_reg, res_cleared_next;
    logic [SLOT_W-1:0]   res_slot_reg, res_slot_next;
    logic                res_wrap_reg, res_wrap_next;
    logic                res_cvalid_reg, res_cvalid_next;
    logic [CURSOR_W-1:0] res_cursor_reg, res_cursor_next;
    logic                res_rvalid_reg, res_rvalid_next;
    logic [RATE_W-1:0]   res_rate_reg, res_rate_next;

    logic                out_valid_reg, out_valid_next;
    logic                out_cleared_reg;
    logic [SAMPLE_W-1:0] out_min_reg;
    logic [SAMPLE_W-1:0] out_max_reg;
    logic [SLOT_W-1:0]   out_slot_reg;
    logic                out_wrap_reg;
    logic                out_cvalid_reg;
    logic [CURSOR_W-1:0] out_cursor_reg;
    logic                out_rvalid_reg;
    logic [RATE_W-1:0]   out_rate_reg;

    logic           accept;
    logic           take;
    logic           do_clear;
    logic           load;
    logic           slots_full;
    logic           ring_full;
    logic [SCW-1:0] sidx_inc;
    logic [CUR_W-1:0] slot_wide;
    logic [CUR_W-1:0] cur_raw;
    logic [CUR_W-1:0] cur_sum;
    logic [AW-1:0]  wr_addr;
    logic [RCW-1:0] rfill_last;

    ring_ctl_t   ring_ctl;
    ring_stat_t  ring_stat;
    beat_ctl_t   beat_ctl;
    logic        beat_rvalid;
    logic [RATE_W-1:0] beat_rate_w;

    assign item_ready = (state_reg == S_IDLE);
    assign accept     = item_valid && item_ready;
    assign take       = accept && (mode == MODE_SAMPLE) && (sample >= floor_reg);
    assign do_clear   = accept && (mode == MODE_CLEAR);
    assign load       = (state_reg == S_LOAD) && (!out_valid_reg || result_ready);

    assign slots_full = (filled_reg >= SCW'(PLOT_SLOTS));
    assign ring_full  = (rfill_reg >= RCW'(WINDOW_LEN));
    assign sidx_inc   = sidx_reg + 1'b1;
    assign cur_raw    = (CUR_W'(sidx_inc) << 2) + CUR_W'(sidx_inc);
    assign cur_sum    = cur_raw + ((cur_raw > CUR_W'(CURSOR_KNEE)) ?
                        CUR_W'(CURSOR_OFS_HI) : CUR_W'(CURSOR_OFS_LO));
    assign slot_wide  = slots_full ? CUR_W'(sidx_reg) : CUR_W'(filled_reg);
    assign wr_addr    = ring_full ? ridx_reg : rfill_reg[AW-1:0];
    assign rfill_last = rfill_next - 1'b1;

    assign beat_ctl.take    = take;
    assign beat_ctl.request = accept && (mode == MODE_REQUEST);
    assign beat_ctl.clear   = do_clear;

    assign ring_ctl.write = take;
    assign ring_ctl.start = take;

    pbwt_beat u_beat (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (beat_ctl),
        .sample       (sample),
        .run_length   (run_len_reg),
        .report_scale (scale_reg),
        .rate_valid   (beat_rvalid),
        .beat_rate    (beat_rate_w)
    );

    pbwt_ring #(
        .WINDOW_LEN (WINDOW_LEN),
        .AW         (AW)
    ) u_ring (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ring_ctl),
        .wr_addr  (wr_addr),
        .wr_data  (sample),
        .last_idx (rfill_last[AW-1:0]),
        .stat     (ring_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg   <= FLOOR_RESET;
            scale_reg   <= SCALE_RESET;
            run_len_reg <= RUN_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FLOOR: floor_reg   <= cfg_data;
                REG_SCALE: scale_reg   <= cfg_data[SCALE_W-1:0];
                REG_RUN:   run_len_reg <= cfg_data[RUN_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        filled_next      = filled_reg;
        sidx_next        = sidx_reg;
        rfill_next       = rfill_reg;
        ridx_next        = ridx_reg;
        res_cleared_next = res_cleared_reg;
        res_slot_next    = res_slot_reg;
        res_wrap_next    = res_wrap_reg;
        res_cvalid_next  = res_cvalid_reg;
        res_cursor_next  = res_cursor_reg;
        res_rvalid_next  = res_rvalid_reg;
        res_rate_next    = res_rate_reg;

        if (do_clear)
        begin
            filled_next      = '0;
            sidx_next        = '0;
            rfill_next       = '0;
            ridx_next        = '0;
            res_cleared_next = 1'b1;
            res_slot_next    = '0;
            res_wrap_next    = 1'b0;
            res_cvalid_next  = 1'b0;
            res_cursor_next  = '0;
            res_rvalid_next  = 1'b0;
            res_rate_next    = '0;
        end

        if (take)
        begin
            res_cleared_next = 1'b0;
            res_slot_next    = slot_wide[SLOT_W-1:0];
            res_wrap_next    = 1'b0;
            res_cvalid_next  = 1'b0;
            res_cursor_next  = '0;
            if (slots_full)
            begin
                res_cvalid_next = 1'b1;
                res_cursor_next = (cur_sum > CUR_W'(CURSOR_MAX)) ?
                                  CURSOR_W'(CURSOR_MAX) : cur_sum[CURSOR_W-1:0];
                if (sidx_inc == SCW'(PLOT_SLOTS))
                begin
                    sidx_next     = '0;
                    res_wrap_next = 1'b1;
                end
                else
                begin
                    sidx_next = sidx_inc;
                end
            end
            else
            begin
                filled_next = filled_reg + 1'b1;
            end

            if (ring_full)
            begin
                ridx_next = (ridx_reg == AW'(WINDOW_LEN - 1)) ? '0 : ridx_reg + 1'b1;
            end
            else
            begin
                rfill_next = rfill_reg + 1'b1;
            end

            res_rvalid_next = beat_rvalid;
            res_rate_next   = beat_rate_w;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    state_next = S_SWEEP;
                end
                else if (do_clear)
                begin
                    state_next = S_LOAD;
                end
            end
            S_SWEEP:
            begin
                if (ring_stat.done)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            filled_reg    <= '0;
            sidx_reg      <= '0;
            rfill_reg     <= '0;
            ridx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            filled_reg    <= filled_next;
            sidx_reg      <= sidx_next;
            rfill_reg     <= rfill_next;
            ridx_reg      <= ridx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_cleared_reg <= res_cleared_next;
        res_slot_reg    <= res_slot_next;
        res_wrap_reg    <= res_wrap_next;
        res_cvalid_reg  <= res_cvalid_next;
        res_cursor_reg  <= res_cursor_next;
        res_rvalid_reg  <= res_rvalid_next;
        res_rate_reg    <= res_rate_next;
        if (load)
        begin
            out_cleared_reg <= res_cleared_reg;
            out_min_reg     <= res_cleared_reg ? '0 : ring_stat.lo;
            out_max_reg     <= res_cleared_reg ? '0 : ring_stat.hi;
            out_slot_reg    <= res_slot_reg;
            out_wrap_reg    <= res_wrap_reg;
            out_cvalid_reg  <= res_cvalid_reg;
            out_cursor_reg  <= res_cursor_reg;
            out_rvalid_reg  <= res_rvalid_reg;
            out_rate_reg    <= res_rate_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign cleared      = out_cleared_reg;
    assign window_min   = out_min_reg;
    assign window_max   = out_max_reg;
    assign slot         = out_slot_reg;
    assign wrap_strobe  = out_wrap_reg;
    assign cursor_valid = out_cvalid_reg;
    assign cursor       = out_cursor_reg;
    assign rate_valid   = out_rvalid_reg;
    assign beat_rate    = out_rate_reg;

endmodule

[sv/pbwt_ring.sv]
// ----------------------------------------------------------------------------
// pbwt_ring
// Sample window memory with a sequential min/max sweep through one shared
// compare unit, one entry per cycle.
// ----------------------------------------------------------------------------
module pbwt_ring #(
    parameter int WINDOW_LEN = pbwt_pkg::WINDOW_LEN_DEF,
    parameter int AW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pbwt_pkg::ring_ctl_t           ctl,
    input  logic [AW-1:0]                 wr_addr,
    input  logic [pbwt_pkg::SAMPLE_W-1:0] wr_data,
    input  logic [AW-1:0]                 last_idx,
    output pbwt_pkg::ring_stat_t          stat
);
    import pbwt_pkg::*;

    logic [SAMPLE_W-1:0] mem [WINDOW_LEN];
    logic [SAMPLE_W-1:0] rd_data_reg;

    logic                active_reg, active_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [AW-1:0]       last_reg, last_next;
    logic                rd_valid_reg, rd_valid_next;
    logic                rd_last_reg, rd_last_next;
    logic                done_reg, done_next;
    logic [SAMPLE_W-1:0] lo_reg, lo_next;
    logic [SAMPLE_W-1:0] hi_reg, hi_next;
    logic                at_last;

    always_ff @(posedge clk)
    begin
        if (ctl.write)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (active_reg)
        begin
            rd_data_reg <= mem[idx_reg];
        end
    end

    assign at_last = (idx_reg == last_reg);

    always_comb
    begin
        active_next   = active_reg;
        idx_next      = idx_reg;
        last_next     = last_reg;
        rd_valid_next = active_reg;
        rd_last_next  = active_reg && at_last;
        done_next     = rd_valid_reg && rd_last_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;

        if (ctl.start)
        begin
            active_next = 1'b1;
            idx_next    = '0;
            last_next   = last_idx;
            lo_next     = SAMPLE_MAX;
            hi_next     = '0;
        end
        else
        begin
            if (active_reg)
            begin
                idx_next = idx_reg + 1'b1;
                if (at_last)
                begin
                    active_next = 1'b0;
                end
            end
            if (rd_valid_reg)
            begin
                if (rd_data_reg < lo_reg)
                begin
                    lo_next = rd_data_reg;
                end
                if (rd_data_reg > hi_reg)
                begin
                    hi_next = rd_data_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            idx_reg      <= '0;
            last_reg     <= '0;
            rd_valid_reg <= 1'b0;
            rd_last_reg  <= 1'b0;
            done_reg     <= 1'b0;
            lo_reg       <= SAMPLE_MAX;
            hi_reg       <= '0;
        end
        else
        begin
            active_reg   <= active_next;
            idx_reg      <= idx_next;
            last_reg     <= last_next;
            rd_valid_reg <= rd_valid_next;
            rd_last_reg  <= rd_last_next;
            done_reg     <= done_next;
            lo_reg       <= lo_next;
            hi_reg       <= hi_next;
        end
    end

    assign stat.done = done_reg;
    assign stat.lo   = lo_reg;
    assign stat.hi   = hi_reg;

endmodule

[sv/pbwt_beat.sv]
// ----------------------------------------------------------------------------
// pbwt_beat
// Peak detector with run-length direction reversal, peak counter and
// scaled, saturating rate report.
// ----------------------------------------------------------------------------
module pbwt_beat (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pbwt_pkg::beat_ctl_t           ctl,
    input  logic [pbwt_pkg::SAMPLE_W-1:0] sample,
    input  logic [pbwt_pkg::RUN_W-1:0]    run_length,
    input  logic [pbwt_pkg::SCALE_W-1:0]  report_scale,
    output logic                          rate_valid,
    output logic [pbwt_pkg::RATE_W-1:0]   beat_rate
);
    import pbwt_pkg::*;

    localparam int PROD_W = SAMPLE_W + SCALE_W;

    logic                pending_reg, pending_next;
    logic                seek_fall_reg, seek_fall_next;
    logic                need_ref_reg, need_ref_next;
    logic [SAMPLE_W-1:0] prev_reg, prev_next;
    logic [RUN_W-1:0]    run_reg, run_next;
    logic [SAMPLE_W-1:0] peaks_reg, peaks_next;

    logic [RUN_W-1:0]    need;
    logic                toward;
    logic [PROD_W-1:0]   product;

    assign need    = (run_length == '0) ? RUN_W'(1) : run_length;
    assign toward  = seek_fall_reg ? (sample > prev_reg) : (sample < prev_reg);

    always_comb
    begin
        pending_next   = pending_reg;
        seek_fall_next = seek_fall_reg;
        need_ref_next  = need_ref_reg;
        prev_next      = prev_reg;
        run_next       = run_reg;
        peaks_next     = peaks_reg;
        rate_valid     = 1'b0;

        if (ctl.request)
        begin
            pending_next = 1'b1;
        end

        if (ctl.clear)
        begin
            run_next   = '0;
            peaks_next = '0;
        end

        if (ctl.take)
        begin
            prev_next = sample;
            if (need_ref_reg)
            begin
                need_ref_next = 1'b0;
            end
            else
            begin
                run_next = toward ? '0 : run_reg + 1'b1;
                if (run_next == need)
                begin
                    if (seek_fall_reg && peaks_reg != SAMPLE_MAX)
                    begin
                        peaks_next = peaks_reg + 1'b1;
                    end
                    run_next       = '0;
                    seek_fall_next = !seek_fall_reg;
                    need_ref_next  = 1'b1;
                end
            end
        end

        product = PROD_W'(peaks_next) * PROD_W'(report_scale);

        if (ctl.take && pending_reg)
        begin
            rate_valid   = 1'b1;
            pending_next = 1'b0;
            peaks_next   = '0;
            run_next     = '0;
        end
    end

    assign beat_rate = !rate_valid ? '0
                     : (product > PROD_W'(RATE_MAX)) ? RATE_MAX
                     : product[RATE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= 1'b0;
            seek_fall_reg <= 1'b1;
            need_ref_reg  <= 1'b1;
            prev_reg      <= '0;
            run_reg       <= '0;
            peaks_reg     <= '0;
        end
        else
        begin
            pending_reg   <= pending_next;
            seek_fall_reg <= seek_fall_next;
            need_ref_reg  <= need_ref_next;
            prev_reg      <= prev_next;
            run_reg       <= run_next;
            peaks_reg     <= peaks_next;
        end
    end

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the plethysmograph beat and window tracker.
// A queue-fed driver sends sample, report and clear words over the item
// channel while a predictor computes each expected result word. The result
// channel is checked field by field, under several register settings and
// with the sender and the receiver idling at random.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import pbwt_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int SLOT_COUNT  = PLOT_SLOTS_DEF;
    localparam int WINDOW_SIZE = WINDOW_LEN_DEF;
    localparam int QUIET_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 100;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [SAMPLE_W-1:0] value;
    } tracker_item_t;

    typedef struct packed {
        logic                cleared;
        logic [SAMPLE_W-1:0] wmin;
        logic [SAMPLE_W-1:0] wmax;
        logic [SLOT_W-1:0]   slot;
        logic                wrap;
        logic                cvalid;
        logic [CURSOR_W-1:0] cursor;
        logic                rvalid;
        logic [RATE_W-1:0]   rate;
    } tracker_word_t;

    logic                clk;
    logic                rst_n = 1'b0;
    logic                cfg_write = 1'b0;
    logic [CFG_IX_W-1:0] cfg_index = REG_FLOOR;
    logic [SAMPLE_W-1:0] cfg_data = '0;
    logic                item_valid = 1'b0;
    logic                item_ready;
    logic [MODE_W-1:0]   mode = MODE_SAMPLE;
    logic [SAMPLE_W-1:0] sample = '0;
    logic                result_valid;
    logic                result_ready = 1'b0;
    logic                cleared;
    logic [SAMPLE_W-1:0] window_min;
    logic [SAMPLE_W-1:0] window_max;
    logic [SLOT_W-1:0]   slot;
    logic                wrap_strobe;
    logic                cursor_valid;
    logic [CURSOR_W-1:0] cursor;
    logic                rate_valid;
    logic [RATE_W-1:0]   beat_rate;

    // predictor state and register copies
    logic [SAMPLE_W-1:0] floor_cfg;
    logic [SCALE_W-1:0]  scale_cfg;
    logic [RUN_W-1:0]    run_cfg;
    logic                rate_armed;
    logic [SLOT_W-1:0]   slots_used;
    logic [SLOT_W-1:0]   slot_ptr;
    logic [SAMPLE_W-1:0] window_mem [WINDOW_SIZE];
    logic [SLOT_W-1:0]   window_used;
    logic [SLOT_W-1:0]   window_ptr;
    logic                hunting_fall;
    logic                want_ref;
    logic [SAMPLE_W-1:0] last_val;
    logic [RUN_W-1:0]    opp_run;
    logic [RATE_W-1:0]   peaks;

    tracker_item_t pending_items [$];
    tracker_word_t words_due [$];
    tracker_item_t next_item;
    tracker_word_t due_word;

    logic word_taken = 1'b0;
    int   sender_idle_pct = 0;
    int   receiver_stall_pct = 0;
    int   quiet_cycles = 0;
    int   mismatches = 0;
    int   words_in = 0;
    int   results_out = 0;
    int   clears_seen = 0;
    int   reports_seen = 0;
    int   wraps_seen = 0;
    int   settings_run = 0;

    pleth_beat_and_window_tracker_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .mode         (mode),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cleared      (cleared),
        .window_min   (window_min),
        .window_max   (window_max),
        .slot         (slot),
        .wrap_strobe  (wrap_strobe),
        .cursor_valid (cursor_valid),
        .cursor       (cursor),
        .rate_valid   (rate_valid),
        .beat_rate    (beat_rate)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic reset_tracker_model();
        floor_cfg    = FLOOR_RESET;
        scale_cfg    = SCALE_RESET;
        run_cfg      = RUN_RESET;
        rate_armed   = 1'b0;
        slots_used   = '0;
        slot_ptr     = '0;
        window_used  = '0;
        window_ptr   = '0;
        hunting_fall = 1'b1;
        want_ref     = 1'b1;
        last_val     = '0;
        opp_run      = '0;
        peaks        = '0;
    endtask

    task automatic predict_tracker_output(input logic [MODE_W-1:0] m,
                                          input logic [SAMPLE_W-1:0] v);
        tracker_word_t w;
        int            cur;
        int            need;
        int            prod;
        logic          toward;
        w = '0;
        if (m == MODE_REQUEST)
        begin
            rate_armed = 1'b1;
            return;
        end
        if (m == MODE_CLEAR)
        begin
            slots_used  = '0;
            slot_ptr    = '0;
            window_used = '0;
            window_ptr  = '0;
            opp_run     = '0;
            peaks       = '0;
            w.cleared   = 1'b1;
            words_due.push_back(w);
            return;
        end
        if (m != MODE_SAMPLE || v < floor_cfg)
            return;

        if (slots_used >= SLOT_COUNT)
        begin
            if (slot_ptr >= SLOT_COUNT)
                slot_ptr = '0;
            w.slot = slot_ptr;
            slot_ptr = slot_ptr + 1'b1;
            cur = int'(slot_ptr) * 5;
            if (slot_ptr == SLOT_COUNT)
            begin
                slot_ptr = '0;
                w.wrap = 1'b1;
            end
            cur += (cur > CURSOR_KNEE) ? CURSOR_OFS_HI : CURSOR_OFS_LO;
            if (cur > CURSOR_MAX)
                cur = CURSOR_MAX;
            w.cursor = cur[CURSOR_W-1:0];
            w.cvalid = 1'b1;
        end
        else
        begin
            w.slot = slots_used;
            slots_used = slots_used + 1'b1;
        end

        if (window_used >= WINDOW_SIZE)
        begin
            if (window_ptr >= WINDOW_SIZE)
                window_ptr = '0;
            window_mem[window_ptr] = v;
            window_ptr = window_ptr + 1'b1;
            if (window_ptr >= WINDOW_SIZE)
                window_ptr = '0;
        end
        else
        begin
            window_mem[window_used] = v;
            window_used = window_used + 1'b1;
        end

        need = (run_cfg == 0) ? 1 : int'(run_cfg);
        if (want_ref)
        begin
            last_val = v;
            want_ref = 1'b0;
        end
        else
        begin
            toward = hunting_fall ? (v > last_val) : (v < last_val);
            opp_run = toward ? '0 : opp_run + 1'b1;
            last_val = v;
            if (int'(opp_run) == need)
            begin
                if (hunting_fall && peaks != RATE_MAX)
                    peaks = peaks + 1'b1;
                opp_run = '0;
                hunting_fall = ~hunting_fall;
                want_ref = 1'b1;
            end
        end

        if (rate_armed)
        begin
            prod = int'(peaks) * int'(scale_cfg);
            rate_armed = 1'b0;
            w.rate = (prod > int'(RATE_MAX)) ? RATE_MAX : prod[RATE_W-1:0];
            w.rvalid = 1'b1;
            peaks = '0;
            opp_run = '0;
        end

        w.wmin = SAMPLE_MAX;
        w.wmax = '0;
        for (int i = 0; i < window_used; i++)
        begin
            if (window_mem[i] < w.wmin)
                w.wmin = window_mem[i];
            if (window_mem[i] > w.wmax)
                w.wmax = window_mem[i];
        end
        words_due.push_back(w);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on result %0d, %s: expected %0h, got %0h",
                         results_out, name, want, got);
        end
    endtask

    task automatic push_item(input logic [MODE_W-1:0] m, input logic [SAMPLE_W-1:0] v);
        tracker_item_t it;
        it.mode  = m;
        it.value = v;
        pending_items.push_back(it);
    endtask

    task automatic write_reg(input logic [CFG_IX_W-1:0] idx, input logic [SAMPLE_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_FLOOR: floor_cfg = data;
            REG_SCALE: scale_cfg = data[SCALE_W-1:0];
            REG_RUN:   run_cfg   = data[RUN_W-1:0];
            default: ;
        endcase
    endtask

    // wait until every item is sent and every result is in, then let the unit settle
    task automatic drain_unit();
        while (pending_items.size() != 0 || item_valid || words_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // rising and falling sample trains at or above the floor, mixed with report
    // requests, rare clears, words of random mode and rejected samples
    task automatic queue_pulse_train(input int count);
        int lo_v;
        int hi_v;
        int step;
        int level;
        int dir;
        int val;
        int r;
        int useful;
        lo_v  = int'(floor_cfg) + $urandom_range(0, 3000);
        hi_v  = lo_v + $urandom_range(50, 4000);
        if (hi_v > 65535)
            hi_v = 65535;
        if (lo_v > hi_v)
            lo_v = hi_v;
        step  = (hi_v - lo_v) / $urandom_range(3, 12) + 1;
        level = lo_v;
        dir   = 1;
        useful = 0;
        while (useful < count)
        begin
            r = $urandom_range(0, 99);
            if (r < 6)
            begin
                push_item(MODE_REQUEST, SAMPLE_W'($urandom));
                useful++;
            end
            else if (r < 7)
            begin
                push_item(MODE_CLEAR, SAMPLE_W'($urandom));
                useful++;
            end
            else if (r < 13)
                push_item(MODE_W'($urandom_range(0, 3)), SAMPLE_W'($urandom));
            else if (r < 16 && floor_cfg != 0)
                push_item(MODE_SAMPLE,
                          SAMPLE_W'($urandom_range(0, int'(floor_cfg) - 1)));
            else
            begin
                val = level + $urandom_range(0, step / 2) - step / 4;
                if (val < int'(floor_cfg))
                    val = int'(floor_cfg);
                if (val > 65535)
                    val = 65535;
                push_item(MODE_SAMPLE, val[SAMPLE_W-1:0]);
                useful++;
                level += dir * step;
                if (level >= hi_v)
                begin
                    level = hi_v;
                    dir = -1;
                    if ($urandom_range(0, 3) == 0)
                        step = (hi_v - lo_v) / $urandom_range(2, 12) + 1;
                end
                else if (level <= lo_v)
                begin
                    level = lo_v;
                    dir = 1;
                end
            end
        end
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input int floor_v,
                             input int scale_v, input int run_v, input int count);
        write_reg(REG_FLOOR, floor_v[SAMPLE_W-1:0]);
        write_reg(REG_SCALE, scale_v[SAMPLE_W-1:0]);
        write_reg(REG_RUN, run_v[SAMPLE_W-1:0]);
        settings_run++;
        sender_idle_pct    = send_pct;
        receiver_stall_pct = recv_pct;
        queue_pulse_train(count);
        drain_unit();
    endtask

    // item channel: advance to the next word once the current one is taken
    always @(negedge clk)
    begin
        if (!rst_n)
            item_valid <= 1'b0;
        else if (!item_valid || word_taken)
        begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
            begin
                next_item = pending_items.pop_front();
                item_valid <= 1'b1;
                mode       <= next_item.mode;
                sample     <= next_item.value;
            end
            else
                item_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        result_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    always @(posedge clk)
    begin
        word_taken <= rst_n && item_valid && item_ready;
        if (rst_n && item_valid && item_ready)
        begin
            words_in++;
            predict_tracker_output(mode, sample);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            results_out++;
            if (words_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %0d with nothing pending", results_out);
            end
            else
            begin
                due_word = words_due.pop_front();
                check_field("cleared", 16'(due_word.cleared), 16'(cleared));
                check_field("window_min", due_word.wmin, window_min);
                check_field("window_max", due_word.wmax, window_max);
                check_field("slot", 16'(due_word.slot), 16'(slot));
                check_field("wrap_strobe", 16'(due_word.wrap), 16'(wrap_strobe));
                check_field("cursor_valid", 16'(due_word.cvalid), 16'(cursor_valid));
                check_field("cursor", 16'(due_word.cursor), 16'(cursor));
                check_field("rate_valid", 16'(due_word.rvalid), 16'(rate_valid));
                check_field("beat_rate", due_word.rate, beat_rate);
                clears_seen  += int'(due_word.cleared);
                reports_seen += int'(due_word.rvalid);
                wraps_seen   += int'(due_word.wrap);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready) || cfg_write)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("stalled for %0d cycles with %0d results outstanding",
                     quiet_cycles, words_due.size());
            $display("testbench failed");
            $finish;
        end
    end

    initial
    begin
        reset_tracker_model();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed words under the reset register values
        push_item(MODE_UNUSED, SAMPLE_MAX);
        push_item(MODE_SAMPLE, 16'd0);
        push_item(MODE_SAMPLE, 16'd99);
        push_item(MODE_SAMPLE, 16'd100);
        push_item(MODE_SAMPLE, SAMPLE_MAX);
        push_item(MODE_REQUEST, 16'd0);
        push_item(MODE_SAMPLE, SAMPLE_MAX);
        push_item(MODE_SAMPLE, 16'd300);
        push_item(MODE_SAMPLE, 16'd250);
        push_item(MODE_SAMPLE, 16'd240);
        push_item(MODE_SAMPLE, 16'd900);
        push_item(MODE_REQUEST, SAMPLE_MAX);
        push_item(MODE_SAMPLE, 16'd101);
        push_item(MODE_REQUEST, 16'd0);
        push_item(MODE_CLEAR, SAMPLE_MAX);
        push_item(MODE_SAMPLE, SAMPLE_MAX);
        push_item(MODE_UNUSED, 16'd0);
        push_item(MODE_SAMPLE, 16'h8000);
        push_item(MODE_SAMPLE, 16'h5555);
        settings_run++;
        drain_unit();

        // floor at its top: only full-scale samples get through
        write_reg(REG_FLOOR, SAMPLE_MAX);
        push_item(MODE_SAMPLE, 16'hFFFE);
        push_item(MODE_SAMPLE, SAMPLE_MAX);
        push_item(MODE_UNUSED, SAMPLE_MAX);
        push_item(MODE_REQUEST, 16'hAAAA);
        push_item(MODE_SAMPLE, SAMPLE_MAX);
        push_item(MODE_CLEAR, 16'd0);
        settings_run++;
        drain_unit();

        run_phase(0, 0, 0, 1, 1, 130);
        run_phase(83, 0, 100, 15, 7, 120);
        run_phase(0, 83, 2000, 0, 0, 120);
        run_phase(13, 13, 500, 7, 2, 120);
        run_phase(83, 0, 0, 15, 3, 120);
        run_phase(0, 83, 30000, 9, 5, 120);
        run_phase(13, 13, 1, 4, 4, 120);
        run_phase(0, 0, 12345, 2, 1, 120);

        mismatches += words_due.size();
        $display("%0d words sent, %0d results checked over %0d register settings",
                 words_in, results_out, settings_run);
        $display("%0d clears, %0d rate reports, %0d slot wraps, %0d mismatches",
                 clears_seen, reports_seen, wraps_seen, mismatches);
        if (mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
